// ----- rtl/dsk_pkg.sv -----
`timescale 1ns / 1ps
package dsk_pkg;

  localparam int unsigned KeyW     = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 32;

  localparam logic [KeyW-1:0] SeedMul = 32'h0319_A267;
  localparam logic [KeyW-1:0] SeedAdd = 32'h116E_F35F;
  localparam logic [15:0]     SeedMod = 16'hFFFF;
  localparam logic [ByteW-1:0] VerBias = 8'd7;

  typedef enum logic [1:0] {
    MODE_RESTART = 2'd0,
    MODE_NEXT_SOLAR = 2'd1,
    MODE_NEXT_LUNAR = 2'd2,
    MODE_EXCHANGE = 2'd3
  } mode_t;

  typedef enum logic {
    REG_MAJOR = 1'b0,
    REG_MINOR = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FOLD,
    ST_KMUL,
    ST_KADD,
    ST_VMUL,
    ST_SVAL,
    ST_LVAL,
    ST_LINC,
    ST_SMUL,
    ST_SADD,
    ST_XCHG,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FOLD,
    OP_KMUL,
    OP_KADD,
    OP_VMUL,
    OP_SVAL,
    OP_LVAL,
    OP_LINC,
    OP_SMUL,
    OP_SADD,
    OP_XCHG
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } dp_cmd_t;

endpackage

// ----- rtl/dual_sequence_key_generator.sv -----
`timescale 1ns / 1ps
// Dual sequence key generator: a solar and a lunar 32-bit key generator.
// Input stream: one transfer is one command. mode picks restart (seed both
// generators from user_key and the version bytes), next solar, next lunar
// or key exchange (store user_key, swap the two increment words).
// Output stream: every command yields exactly one transfer carrying the four
// key bytes as they stand after the command.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr
// (0 major version, 1 minor version); write only while the block is idle.
// Sequence from input transfer to output valid: restart walks FOLD, KMUL,
// KADD, VMUL, SVAL, LVAL, LINC and DONE; next walks SMUL, SADD and DONE;
// exchange walks XCHG and DONE. One command is in work at a time; without
// stalls the next input transfer can come in the cycle in which output valid
// rises. The chains are set by the single shared 32x16 multiplier, which the
// restart chain uses twice, with the adds in the states behind it.
// The output register holds a finished result while the receiver stalls;
// the next command is taken meanwhile and completes into the output register
// once the held result has been transferred.
// Reset (rst_n low at a clock edge) clears all generator state, the version
// registers and the output valid flag.
module dual_sequence_key_generator
  import dsk_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // configuration write port
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [ByteW-1:0]    cfg_wdata,
  // command stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // [1:0] mode, [33:2] user_key, [39:34] zero
  // key stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata   // [7:0] solar_base_key, [15:8] solar_pair_key,
                                          // [23:16] lunar_base_key, [31:24] lunar_pair_key
);

  dp_cmd_t cmd;

  // sequencer: walks the seed, step and exchange command sequences
  dsk_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (in_tdata[1:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // generator state, shared multiplier and output register
  dsk_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_mode     (in_tdata[1:0]),
    .in_user_key (in_tdata[33:2]),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .out_data    (out_tdata)
  );

endmodule

// ----- rtl/dsk_ctrl.sv -----
`timescale 1ns / 1ps
module dsk_ctrl
  import dsk_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [1:0] in_mode,
  output logic       out_tvalid,
  input  logic       out_tready,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   load_ok;
  mode_t  mode_in;

  assign mode_in    = mode_t'(in_mode);
  assign load_ok    = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          unique case (mode_in)
            MODE_RESTART:    state_nxt = ST_FOLD;
            MODE_NEXT_SOLAR: state_nxt = ST_SMUL;
            MODE_NEXT_LUNAR: state_nxt = ST_SMUL;
            MODE_EXCHANGE:   state_nxt = ST_XCHG;
            default:         state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FOLD: state_nxt = ST_KMUL;
      ST_KMUL: state_nxt = ST_KADD;
      ST_KADD: state_nxt = ST_VMUL;
      ST_VMUL: state_nxt = ST_SVAL;
      ST_SVAL: state_nxt = ST_LVAL;
      ST_LVAL: state_nxt = ST_LINC;
      ST_LINC: state_nxt = ST_DONE;
      ST_SMUL: state_nxt = ST_SADD;
      ST_SADD: state_nxt = ST_DONE;
      ST_XCHG: state_nxt = ST_DONE;
      ST_DONE: begin
        if (load_ok) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: cmd.op = in_tvalid ? OP_LOAD : OP_NONE;
      ST_FOLD: cmd.op = OP_FOLD;
      ST_KMUL: cmd.op = OP_KMUL;
      ST_KADD: cmd.op = OP_KADD;
      ST_VMUL: cmd.op = OP_VMUL;
      ST_SVAL: cmd.op = OP_SVAL;
      ST_LVAL: cmd.op = OP_LVAL;
      ST_LINC: cmd.op = OP_LINC;
      ST_SMUL: cmd.op = OP_SMUL;
      ST_SADD: cmd.op = OP_SADD;
      ST_XCHG: cmd.op = OP_XCHG;
      ST_DONE: cmd.out_load = load_ok;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/dsk_datapath.sv -----
`timescale 1ns / 1ps
module dsk_datapath
  import dsk_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  input  logic [1:0]          in_mode,
  input  logic [KeyW-1:0]     in_user_key,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [ByteW-1:0]    cfg_wdata,
  output logic [OutDataW-1:0] out_data
);

  // configuration
  logic [ByteW-1:0] major_r, minor_r;

  // architectural state
  logic [KeyW-1:0]  user_key_r;
  logic [KeyW-1:0]  solar_val_r, lunar_val_r;
  logic [KeyW-1:0]  solar_inc_r, lunar_inc_r;
  logic [ByteW-1:0] solar_base_r, solar_pair_r, lunar_base_r, lunar_pair_r;

  // working registers
  mode_t            mode_r;
  logic [KeyW-1:0]  key_in_r;
  logic [15:0]      rem_r;
  logic [KeyW-1:0]  prod_r;
  logic [OutDataW-1:0] out_data_r;

  // shared multiplier, 32 x 16, low 32 bits kept
  logic [KeyW-1:0]  mul_a;
  logic [15:0]      mul_b;
  logic [KeyW-1:0]  mul_full;

  logic [ByteW-1:0] ver_major, ver_minor;
  logic [16:0]      fold_sum;
  logic [15:0]      fold_wrap;
  logic [15:0]      fold_rem;
  logic             step_lunar;
  logic [KeyW-1:0]  step_inc, step_val, step_new;
  logic [KeyW-1:0]  solar_seed_inc, lunar_seed_inc;
  logic [KeyW-1:0]  solar_stepped, lunar_stepped;

  assign ver_major  = major_r + VerBias;
  assign ver_minor  = minor_r + ver_major;
  assign step_lunar = (mode_r == MODE_NEXT_LUNAR);
  assign step_inc   = step_lunar ? lunar_inc_r : solar_inc_r;
  assign step_val   = step_lunar ? lunar_val_r : solar_val_r;

  always_comb begin
    mul_a = SeedMul;
    mul_b = rem_r;
    unique case (cmd.op)
      OP_VMUL: begin
        mul_a = user_key_r;
        mul_b = {ver_major, ver_minor};
      end
      OP_SMUL: begin
        mul_a = step_inc;
        mul_b = {8'd0, step_lunar ? lunar_base_r : solar_base_r};
      end
      default: begin
        mul_a = SeedMul;
        mul_b = rem_r;
      end
    endcase
  end

  assign mul_full = mul_a * {16'd0, mul_b};

  // key mod 0xFFFF: fold the halves, wrap the carry, map 0xFFFF to zero
  assign fold_sum  = {1'b0, key_in_r[31:16]} + {1'b0, key_in_r[15:0]};
  assign fold_wrap = fold_sum[15:0] + {15'd0, fold_sum[16]};
  assign fold_rem  = (fold_wrap == SeedMod) ? 16'd0 : fold_wrap;

  // after seeding the base byte is zero, so the step is value + (inc >> 16)
  assign solar_seed_inc = ~solar_val_r;
  assign lunar_seed_inc = ~lunar_val_r;
  assign solar_stepped  = solar_val_r + {16'd0, solar_seed_inc[31:16]};
  assign lunar_stepped  = lunar_val_r + {16'd0, lunar_seed_inc[31:16]};
  assign step_new       = prod_r + step_val + {16'd0, step_inc[31:16]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      major_r <= '0;
      minor_r <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_MAJOR: major_r <= cfg_wdata;
        REG_MINOR: minor_r <= cfg_wdata;
        default:   major_r <= major_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      user_key_r   <= '0;
      solar_val_r  <= '0;
      lunar_val_r  <= '0;
      solar_inc_r  <= '0;
      lunar_inc_r  <= '0;
      solar_base_r <= '0;
      solar_pair_r <= '0;
      lunar_base_r <= '0;
      lunar_pair_r <= '0;
    end else begin
      unique case (cmd.op)
        OP_KADD: user_key_r <= prod_r + SeedAdd;
        OP_SVAL: solar_val_r <= prod_r + {16'd0, user_key_r[31:16]};
        OP_LVAL: begin
          lunar_val_r  <= prod_r + {16'd0, solar_val_r[31:16]};
          solar_inc_r  <= solar_stepped;
          solar_base_r <= solar_stepped[31:24];
          solar_pair_r <= solar_stepped[23:16];
        end
        OP_LINC: begin
          lunar_inc_r  <= lunar_stepped;
          lunar_base_r <= lunar_stepped[31:24];
          lunar_pair_r <= lunar_stepped[23:16];
        end
        OP_SADD: begin
          if (step_lunar) begin
            lunar_inc_r  <= step_new;
            lunar_base_r <= step_new[31:24];
            lunar_pair_r <= step_new[23:16];
          end else begin
            solar_inc_r  <= step_new;
            solar_base_r <= step_new[31:24];
            solar_pair_r <= step_new[23:16];
          end
        end
        OP_XCHG: begin
          user_key_r  <= key_in_r;
          solar_inc_r <= lunar_inc_r;
          lunar_inc_r <= solar_inc_r;
        end
        default: user_key_r <= user_key_r;
      endcase
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      mode_r   <= mode_t'(in_mode);
      key_in_r <= in_user_key;
    end
    if (cmd.op == OP_FOLD) rem_r <= fold_rem;
    if (cmd.op == OP_KMUL || cmd.op == OP_VMUL || cmd.op == OP_SMUL) begin
      prod_r <= mul_full;
    end
    if (cmd.out_load) begin
      out_data_r <= {lunar_pair_r, lunar_base_r, solar_pair_r, solar_base_r};
    end
  end

  assign out_data = out_data_r;

endmodule
